// ===== rtl/ddcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddcf_pkg
// Types and constants shared by the differential drive command framer.
// ----------------------------------------------------------------------------
package ddcf_pkg;

	localparam int unsigned FRAME_LEN   = 10;
	localparam int unsigned FRAME_BYTES = 2 * FRAME_LEN;
	localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
	localparam int unsigned BYTE_IDX_W  = $clog2(FRAME_LEN);

	localparam logic [7:0]  CENTRE    = 8'h2a;
	localparam logic [7:0]  REV_LO    = 8'h20;
	localparam logic [7:0]  REV_HI    = 8'h29;
	localparam logic [15:0] REV_FLAG  = 16'h8000;
	localparam logic [7:0]  HDR0      = 8'h55;
	localparam logic [7:0]  HDR1      = 8'haa;
	localparam logic [7:0]  DEV_ID    = 8'h01;
	localparam logic [7:0]  PAYLOAD   = 8'h04;
	localparam logic [7:0]  CMD_ACCEL = 8'h27;
	localparam logic [7:0]  CMD_SPEED = 8'h26;
	localparam logic [7:0]  ACCEL_SUM = 8'h2d;

	localparam logic [7:0] ACCEL_FRAME [FRAME_LEN] = '{
		HDR0, HDR1, DEV_ID, PAYLOAD, CMD_ACCEL, 8'h00, 8'h01, 8'h00, 8'h01, ACCEL_SUM
	};

	typedef struct packed {
		logic [7:0] stick_x;
		logic [7:0] stick_y;
	} sample_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} tx_result_t;

endpackage

`default_nettype wire

// ===== rtl/differential_drive_command_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_command_framer
// Turns one joystick sample into an acceleration frame and a speed frame,
// one byte per cycle.
// ----------------------------------------------------------------------------
// channel | ports                  | transfer
// sample  | start, busy, sample    | edge with start high and busy low
// result  | valid, result          | every edge that ends a cycle with valid
//
// One sample yields 20 bytes, one per cycle; the byte counter indexes them.
// The sample transfer loads the counter and the held sample, and the
// first byte is registered onto result from them. busy drops while the
// last byte is being registered, so the next sample can follow without a
// gap. Reset clears the counter and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module differential_drive_command_framer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  ddcf_pkg::sample_t     sample,
	output logic                  valid,
	output ddcf_pkg::tx_result_t  result
);

	localparam logic [ddcf_pkg::IDX_W-1:0] LAST_IDX = ddcf_pkg::IDX_W'(ddcf_pkg::FRAME_BYTES - 1);

	ddcf_pkg::sample_t          in_q;
	logic                       active_q;
	logic [ddcf_pkg::IDX_W-1:0] cnt_q;
	logic                       valid_q;
	ddcf_pkg::tx_result_t       result_q;

	logic        accept;
	logic        rev_x, rev_y;
	logic [15:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
	logic [15:0] base, left, right;
	logic [7:0]  speed [ddcf_pkg::FRAME_LEN];
	logic [7:0]  csum;
	logic [7:0]  next_byte;
	logic [ddcf_pkg::BYTE_IDX_W-1:0] byte_idx;

	function automatic logic [15:0] scaled_diff(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] d;
		d = {8'h00, a} - {8'h00, b};
		return (d << 6) + (d << 5);
	endfunction

	assign accept = start && !busy;
	assign busy   = active_q && (cnt_q != LAST_IDX);

	always_comb begin
		rev_x  = in_q.stick_x inside {[ddcf_pkg::REV_LO:ddcf_pkg::REV_HI]};
		rev_y  = in_q.stick_y inside {[ddcf_pkg::REV_LO:ddcf_pkg::REV_HI]};
		dx_fwd = scaled_diff(in_q.stick_x, ddcf_pkg::CENTRE);
		dx_rev = scaled_diff(ddcf_pkg::CENTRE, in_q.stick_x);
		dy_fwd = scaled_diff(in_q.stick_y, ddcf_pkg::CENTRE);
		dy_rev = scaled_diff(ddcf_pkg::CENTRE, in_q.stick_y);
		base   = rev_y ? (ddcf_pkg::REV_FLAG + dy_rev) : dy_fwd;
		if (in_q.stick_y == ddcf_pkg::CENTRE) begin
			if (rev_x) begin
				right = dx_rev;
				left  = ddcf_pkg::REV_FLAG + dx_rev;
			end else begin
				left  = dx_fwd;
				right = ddcf_pkg::REV_FLAG + dx_fwd;
			end
		end else if (rev_x) begin
			left  = base;
			right = base + dx_rev;
		end else begin
			left  = base + dx_fwd;
			right = base;
		end
		speed[0] = ddcf_pkg::HDR0;
		speed[1] = ddcf_pkg::HDR1;
		speed[2] = ddcf_pkg::DEV_ID;
		speed[3] = ddcf_pkg::PAYLOAD;
		speed[4] = ddcf_pkg::CMD_SPEED;
		speed[5] = left[15:8];
		speed[6] = left[7:0];
		speed[7] = right[15:8];
		speed[8] = right[7:0];
		csum = ddcf_pkg::HDR0 + ddcf_pkg::HDR1 + ddcf_pkg::DEV_ID + ddcf_pkg::PAYLOAD
			+ ddcf_pkg::CMD_SPEED + left[15:8] + left[7:0] + right[15:8] + right[7:0];
		speed[9] = csum;
		if (cnt_q < ddcf_pkg::IDX_W'(ddcf_pkg::FRAME_LEN)) begin
			byte_idx  = ddcf_pkg::BYTE_IDX_W'(cnt_q);
			next_byte = ddcf_pkg::ACCEL_FRAME[byte_idx];
		end else begin
			byte_idx  = ddcf_pkg::BYTE_IDX_W'(cnt_q - ddcf_pkg::IDX_W'(ddcf_pkg::FRAME_LEN));
			next_byte = speed[byte_idx];
		end
	end

	// track the active flag, advance the byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == LAST_IDX) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				cnt_q    <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q.tx_byte   <= next_byte;
			result_q.frame_end <= (cnt_q == LAST_IDX);
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_IDX)
		else $error("byte counter out of range");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(active_q))
		else $error("strobe without a byte in progress");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##21 (valid && result.frame_end))
		else $error("speed frame did not end 21 cycles after transfer");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential drive command framer. A queue of
// joystick samples, directed corner values first and then random ones,
// feeds a clocked driver that works in bursts with random gaps. Each sample
// transfer is turned into the 20 expected frame bytes by a local speed and
// checksum calculation. A clocked monitor compares every strobed byte with
// the oldest expected one. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_SAMPLES = 500;
	localparam int IDLE_LIMIT     = 2000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int MAX_REPORTS    = 100;
	localparam logic [15:0] SPEED_STEP = 16'h0060;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	ddcf_pkg::sample_t    sample = '0;
	logic                 busy;
	logic                 valid;
	ddcf_pkg::tx_result_t result;

	ddcf_pkg::sample_t    sample_q[$];
	ddcf_pkg::tx_result_t tx_expect_q[$];

	int samples_total;
	int samples_sent    = 0;
	int bytes_checked   = 0;
	int errors          = 0;
	int spin_samples    = 0;
	int reverse_samples = 0;
	int gap_left;
	int burst_left;
	int idle_cycles     = 0;

	differential_drive_command_framer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.valid  (valid),
		.result (result)
	);

	always #1 clk = ~clk;

	function automatic logic is_reverse(logic [7:0] v);
		return (v >= ddcf_pkg::REV_LO) && (v <= ddcf_pkg::REV_HI);
	endfunction

	function automatic logic [15:0] scaled_diff(logic [7:0] a, logic [7:0] b);
		logic [15:0] d;
		d = {8'h00, a} - {8'h00, b};
		return d * SPEED_STEP;
	endfunction

	function automatic void frame_sample(ddcf_pkg::sample_t s);
		logic [15:0] left;
		logic [15:0] right;
		logic [7:0]  speed [ddcf_pkg::FRAME_LEN];
		logic [7:0]  sum;
		ddcf_pkg::tx_result_t r;
		if (is_reverse(s.stick_y)) begin
			left = ddcf_pkg::REV_FLAG + scaled_diff(ddcf_pkg::CENTRE, s.stick_y);
		end else begin
			left = scaled_diff(s.stick_y, ddcf_pkg::CENTRE);
		end
		right = left;
		if (is_reverse(s.stick_x)) begin
			right = right + scaled_diff(ddcf_pkg::CENTRE, s.stick_x);
		end else begin
			left = left + scaled_diff(s.stick_x, ddcf_pkg::CENTRE);
		end
		if (s.stick_y == ddcf_pkg::CENTRE) begin
			if (is_reverse(s.stick_x)) begin
				right = scaled_diff(ddcf_pkg::CENTRE, s.stick_x);
				left  = ddcf_pkg::REV_FLAG + right;
			end else begin
				left  = scaled_diff(s.stick_x, ddcf_pkg::CENTRE);
				right = ddcf_pkg::REV_FLAG + left;
			end
		end
		speed[0] = ddcf_pkg::HDR0;
		speed[1] = ddcf_pkg::HDR1;
		speed[2] = ddcf_pkg::DEV_ID;
		speed[3] = ddcf_pkg::PAYLOAD;
		speed[4] = ddcf_pkg::CMD_SPEED;
		speed[5] = left[15:8];
		speed[6] = left[7:0];
		speed[7] = right[15:8];
		speed[8] = right[7:0];
		sum = 8'h00;
		for (int i = 0; i < ddcf_pkg::FRAME_LEN - 1; i++) begin
			sum = sum + speed[i];
		end
		speed[ddcf_pkg::FRAME_LEN - 1] = sum;
		for (int i = 0; i < ddcf_pkg::FRAME_LEN; i++) begin
			r.tx_byte   = ddcf_pkg::ACCEL_FRAME[i];
			r.frame_end = 1'b0;
			tx_expect_q.push_back(r);
		end
		for (int i = 0; i < ddcf_pkg::FRAME_LEN; i++) begin
			r.tx_byte   = speed[i];
			r.frame_end = (i == ddcf_pkg::FRAME_LEN - 1);
			tx_expect_q.push_back(r);
		end
	endfunction

	function automatic logic [7:0] pick_coord();
		case ($urandom_range(0, 4))
			0: begin
				return ddcf_pkg::REV_LO + 8'($urandom_range(0, 9));
			end
			1: begin
				return ddcf_pkg::CENTRE;
			end
			2: begin
				return 8'h18 + 8'($urandom_range(0, 24));
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// driver: hold start until the transfer, then present the next sample
	always @(posedge clk or negedge arst_n) begin : driver
		logic nxt_start;
		int   nxt_gap;
		int   nxt_burst;
		if (!arst_n) begin
			start      <= 1'b0;
			sample     <= '0;
			gap_left   <= 0;
			burst_left <= 0;
		end else begin
			nxt_start = start;
			nxt_gap   = gap_left;
			nxt_burst = burst_left;
			if (start && !busy) begin
				frame_sample(sample);
				samples_sent++;
				if (sample.stick_y == ddcf_pkg::CENTRE) spin_samples++;
				if (is_reverse(sample.stick_y)) reverse_samples++;
				nxt_start = 1'b0;
			end
			if (!nxt_start) begin
				if (nxt_gap != 0) begin
					nxt_gap--;
				end else if (sample_q.size() != 0) begin
					sample <= sample_q.pop_front();
					nxt_start = 1'b1;
					if (nxt_burst == 0) begin
						nxt_burst = ($urandom_range(0, 5) == 0) ? 20 : $urandom_range(1, 8);
					end
					nxt_burst--;
					if (nxt_burst == 0) begin
						nxt_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
			start      <= nxt_start;
			gap_left   <= nxt_gap;
			burst_left <= nxt_burst;
		end
	end

	// monitor: every strobed byte is a transfer
	always @(posedge clk) begin : monitor
		ddcf_pkg::tx_result_t want;
		if (arst_n && valid) begin
			if (tx_expect_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: unexpected byte, expected none, actual %h/%b",
						$time, result.tx_byte, result.frame_end);
				end
			end else begin
				want = tx_expect_q.pop_front();
				if (result.tx_byte !== want.tx_byte || result.frame_end !== want.frame_end) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: byte %0d expected %h/%b actual %h/%b", $time,
							bytes_checked, want.tx_byte, want.frame_end,
							result.tx_byte, result.frame_end);
					end
				end
			end
			bytes_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("differential_drive_command_framer: mismatch");
			$finish;
		end
	end

	initial begin
		ddcf_pkg::sample_t s;
		logic [7:0] corner [22][2] = '{
			'{8'h2a, 8'h2a}, '{8'h20, 8'h2a}, '{8'h29, 8'h2a}, '{8'h2a, 8'h20},
			'{8'h2a, 8'h29}, '{8'h20, 8'h20}, '{8'h29, 8'h29}, '{8'h00, 8'h00},
			'{8'hff, 8'hff}, '{8'h00, 8'h2a}, '{8'h2a, 8'h00}, '{8'hff, 8'h2a},
			'{8'h2a, 8'hff}, '{8'h1f, 8'h2a}, '{8'h2b, 8'h2a}, '{8'h30, 8'h1f},
			'{8'h21, 8'h55}, '{8'h80, 8'h28}, '{8'haa, 8'h55}, '{8'h55, 8'haa},
			'{8'hff, 8'h00}, '{8'h00, 8'hff}
		};
		for (int i = 0; i < 22; i++) begin
			s.stick_x = corner[i][0];
			s.stick_y = corner[i][1];
			sample_q.push_back(s);
		end
		for (int i = 0; i < RANDOM_SAMPLES; i++) begin
			s.stick_x = pick_coord();
			s.stick_y = pick_coord();
			sample_q.push_back(s);
		end
		samples_total = sample_q.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (samples_sent != samples_total) @(posedge clk);
		while (tx_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Framed %0d joystick samples (%0d spin in place, %0d reverse throttle),",
			samples_sent, spin_samples, reverse_samples);
		$display("checked %0d transmitted bytes, %0d errors.", bytes_checked, errors);
		if (errors == 0) begin
			$display("differential_drive_command_framer: match");
		end else begin
			$display("differential_drive_command_framer: mismatch");
		end
		$finish;
	end

endmodule
